// ===== rtl/smfd_pkg.sv =====
// ----------------------------------------------------------------------------
// smfd_pkg
// Types, codes and constants shared by the scan mixed-flag detector modules.
// ----------------------------------------------------------------------------
package smfd_pkg;

    localparam int TIME_W     = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [TIME_W-1:0] TIME_MAX = 40'hFF_FFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_CORR_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IF_STRIDE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_STRIDE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOKES_STRIDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANTENNA_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_MARGIN   = 3'd5;

    localparam logic [4:0]  RST_CORR_COUNT    = 5'd4;
    localparam logic [4:0]  RST_IF_STRIDE     = 5'd4;
    localparam logic [4:0]  RST_CHAN_STRIDE   = 5'd4;
    localparam logic [4:0]  RST_STOKES_STRIDE = 5'd1;
    localparam logic [5:0]  RST_ANTENNA_LIMIT = 6'd32;
    localparam logic [19:0] RST_TIME_MARGIN   = 20'd86400;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_FETCH  = 2'd1,
        ACT_END    = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_ACCEPTED = 2'd0,
        STS_FLAG     = 2'd1,
        STS_NO_MORE  = 2'd2,
        STS_OVERRUN  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_INIT_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_OVR_CLEAR,
        ST_COMMIT,
        ST_FETCH_RD,
        ST_FETCH_CHK,
        ST_DIV_BL,
        ST_DIV_IF,
        ST_DIV_CH,
        ST_DIV_ST
    } t_state;

    typedef enum logic [1:0] {
        DIV_BL = 2'd0,
        DIV_IF = 2'd1,
        DIV_CH = 2'd2,
        DIV_ST = 2'd3
    } t_div_sel;

    typedef struct packed {
        t_action          action;
        logic [15:0]      source_id;
        logic [7:0]       subarray;
        logic [TIME_W-1:0] sample_time;
        logic [5:0]       ant_first;
        logic [5:0]       ant_second;
        logic [3:0]       corr_index;
        logic             weight_positive;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [15:0]       flag_source;
        logic [7:0]        flag_subarray;
        logic [TIME_W-1:0] window_begin;
        logic [TIME_W-1:0] window_end;
        logic [5:0]        flag_ant_first;
        logic [5:0]        flag_ant_second;
        logic [4:0]        flag_if;
        logic [4:0]        flag_channel;
        logic [3:0]        flag_stokes;
    } t_result;

    typedef struct packed {
        logic     load;
        logic     set_ovr;
        logic     clr_en;
        logic     clr_all;
        logic     commit;
        logic     rd_clear;
        logic     drain_end;
        logic     div_load;
        t_div_sel load_sel;
        logic     cap_en;
        t_div_sel cap_sel;
        logic     emit;
        t_status  emit_status;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    close_req;
        logic    scan_open;
        logic    pending;
        logic    overrun;
        logic    ptr_end;
        logic    hit;
        logic    div_done;
        logic    clr_last_all;
        logic    clr_last_bank;
    } t_stat;

endpackage

// ===== rtl/scan_mixed_flag_detector.sv =====
// ----------------------------------------------------------------------------
// scan_mixed_flag_detector
// Collects good and bad marks per baseline and correlation for each scan and
// returns flag records for entries that hold both.
// ----------------------------------------------------------------------------
// An item transfer happens on a rising edge with start high and busy low; the
// item's action selects a sample, a fetch of the next flag record, or an end
// of data. Every item gives exactly one result on o_result, marked by o_done
// for one cycle; the receiver cannot stall it. Configuration registers are
// written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must write
// them only while the block is idle, as the block does not enforce it. A
// sample, or an end of data that closes a scan, passes the decode and commit
// states before o_done rises; an end of data with no open scan, a fetch with
// no drain pending and an ignored action emit straight from the decode state.
// A close that meets a pending drain first sweeps the old closed bank. A fetch
// reads and clears the entries of the closed bank one at a time, each in a
// read and a check state, through the single memory read port; a hit then
// runs four divisions on one shared restoring divider before the result.
// After reset both banks are swept to zero with busy high; configuration
// writes are taken during that sweep.
// ----------------------------------------------------------------------------
module scan_mixed_flag_detector #(
    parameter int MAX_ANTENNAS = 32,
    parameter int MAX_CORR     = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  smfd_pkg::t_item                 i_item,
    output logic                            o_done,
    output smfd_pkg::t_result               o_result,
    input  logic                            i_cfg_we,
    input  logic [smfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [smfd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    smfd_pkg::t_cmd  w_cmd;
    smfd_pkg::t_stat w_stat;

    smfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    smfd_dp #(
        .MAX_ANTENNAS (MAX_ANTENNAS),
        .MAX_CORR     (MAX_CORR)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

// ===== rtl/smfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// smfd_ctrl
// Controller state machine: sequences clearing sweeps, sample commits, the
// drain walk and the decode divisions, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module smfd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  smfd_pkg::t_stat i_stat,
    output smfd_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    smfd_pkg::t_state r_state;
    smfd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smfd_pkg::ST_INIT_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != smfd_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            smfd_pkg::ST_INIT_CLEAR: begin
                o_cmd.clr_en  = 1'b1;
                o_cmd.clr_all = 1'b1;
                if (i_stat.clr_last_all) begin
                    n_state = smfd_pkg::ST_IDLE;
                end
            end
            smfd_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = smfd_pkg::ST_DECODE;
                end
            end
            smfd_pkg::ST_DECODE: begin
                unique case (i_stat.action) inside
                    smfd_pkg::ACT_SAMPLE, smfd_pkg::ACT_END: begin
                        if (i_stat.action == smfd_pkg::ACT_END && !i_stat.scan_open) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = smfd_pkg::STS_ACCEPTED;
                            n_state           = smfd_pkg::ST_IDLE;
                        end else if (i_stat.close_req && i_stat.pending) begin
                            o_cmd.set_ovr = 1'b1;
                            n_state       = smfd_pkg::ST_OVR_CLEAR;
                        end else begin
                            n_state = smfd_pkg::ST_COMMIT;
                        end
                    end
                    smfd_pkg::ACT_FETCH: begin
                        if (i_stat.pending) begin
                            n_state = smfd_pkg::ST_FETCH_RD;
                        end else begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = smfd_pkg::STS_NO_MORE;
                            n_state           = smfd_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = smfd_pkg::STS_ACCEPTED;
                        n_state           = smfd_pkg::ST_IDLE;
                    end
                endcase
            end
            smfd_pkg::ST_OVR_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_last_bank) begin
                    n_state = smfd_pkg::ST_COMMIT;
                end
            end
            smfd_pkg::ST_COMMIT: begin
                o_cmd.commit      = 1'b1;
                o_cmd.emit        = 1'b1;
                o_cmd.emit_status = i_stat.overrun ? smfd_pkg::STS_OVERRUN
                                                   : smfd_pkg::STS_ACCEPTED;
                n_state           = smfd_pkg::ST_IDLE;
            end
            smfd_pkg::ST_FETCH_RD: begin
                if (i_stat.ptr_end) begin
                    o_cmd.drain_end   = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = smfd_pkg::STS_NO_MORE;
                    n_state           = smfd_pkg::ST_IDLE;
                end else begin
                    o_cmd.rd_clear = 1'b1;
                    n_state        = smfd_pkg::ST_FETCH_CHK;
                end
            end
            smfd_pkg::ST_FETCH_CHK: begin
                if (i_stat.hit) begin
                    o_cmd.div_load = 1'b1;
                    o_cmd.load_sel = smfd_pkg::DIV_BL;
                    n_state        = smfd_pkg::ST_DIV_BL;
                end else begin
                    n_state = smfd_pkg::ST_FETCH_RD;
                end
            end
            smfd_pkg::ST_DIV_BL: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_en   = 1'b1;
                    o_cmd.cap_sel  = smfd_pkg::DIV_BL;
                    o_cmd.div_load = 1'b1;
                    o_cmd.load_sel = smfd_pkg::DIV_IF;
                    n_state        = smfd_pkg::ST_DIV_IF;
                end
            end
            smfd_pkg::ST_DIV_IF: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_en   = 1'b1;
                    o_cmd.cap_sel  = smfd_pkg::DIV_IF;
                    o_cmd.div_load = 1'b1;
                    o_cmd.load_sel = smfd_pkg::DIV_CH;
                    n_state        = smfd_pkg::ST_DIV_CH;
                end
            end
            smfd_pkg::ST_DIV_CH: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_en   = 1'b1;
                    o_cmd.cap_sel  = smfd_pkg::DIV_CH;
                    o_cmd.div_load = 1'b1;
                    o_cmd.load_sel = smfd_pkg::DIV_ST;
                    n_state        = smfd_pkg::ST_DIV_ST;
                end
            end
            smfd_pkg::ST_DIV_ST: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_en      = 1'b1;
                    o_cmd.cap_sel     = smfd_pkg::DIV_ST;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = smfd_pkg::STS_FLAG;
                    n_state           = smfd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = smfd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/smfd_div.sv =====
// ----------------------------------------------------------------------------
// smfd_div
// Restoring divider, one quotient bit per cycle, used for the index decode.
// ----------------------------------------------------------------------------
module smfd_div #(
    parameter int NUM_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [NUM_W-1:0] i_num,
    input  logic [5:0]       i_den,
    output logic [NUM_W-1:0] o_quot,
    output logic [5:0]       o_rem,
    output logic             o_done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [5:0]       r_rem;
    logic [5:0]       r_den;
    logic [6:0]       w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? 6'(w_trial - {1'b0, r_den}) : w_trial[5:0];
        end
    end

    assign o_quot = r_num;
    assign o_rem  = r_rem;
    assign o_done = (r_cnt == '0);

endmodule

// ===== rtl/smfd_dp.sv =====
// ----------------------------------------------------------------------------
// smfd_dp
// Datapath: configuration registers, scan state, the two-bank mark memory,
// drain pointer, decode registers and the result register.
// ----------------------------------------------------------------------------
module smfd_dp #(
    parameter int MAX_ANTENNAS = 32,
    parameter int MAX_CORR     = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [smfd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [smfd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  smfd_pkg::t_item                     i_item,
    input  smfd_pkg::t_cmd                      i_cmd,
    output smfd_pkg::t_stat                     o_stat,
    output logic                                o_done,
    output smfd_pkg::t_result                   o_result
);

    localparam int LW        = $clog2(MAX_ANTENNAS * MAX_ANTENNAS * MAX_CORR);
    localparam int AW        = LW + 1;
    localparam int MEM_DEPTH = 2 ** AW;
    localparam int BLW       = $clog2(MAX_ANTENNAS * MAX_ANTENNAS);
    localparam int PW        = $clog2(MAX_ANTENNAS * MAX_ANTENNAS + 1);
    localparam int CW        = (MAX_CORR > 1) ? $clog2(MAX_CORR) : 1;
    localparam int NW        = (BLW > CW) ? BLW : CW;
    localparam int QW        = NW + 1;
    localparam int TW        = smfd_pkg::TIME_W;

    logic [4:0]  r_corr_count;
    logic [4:0]  r_if_stride;
    logic [4:0]  r_chan_stride;
    logic [4:0]  r_stokes_stride;
    logic [5:0]  r_antenna_limit;
    logic [19:0] r_time_margin;

    smfd_pkg::t_item r_in;
    logic [BLW-1:0]  r_bl;

    logic            r_bank;
    logic            r_open;
    logic            r_pending;
    logic            r_ovr;
    logic [15:0]     r_osrc;
    logic [7:0]      r_osub;
    logic [TW-1:0]   r_obeg;
    logic [TW-1:0]   r_oend;
    logic [15:0]     r_csrc;
    logic [7:0]      r_csub;
    logic [TW-1:0]   r_cbeg;
    logic [TW-1:0]   r_cend;

    logic [PW-1:0]   r_dbl;
    logic [CW-1:0]   r_dc;
    logic [BLW-1:0]  r_cur_bl;
    logic [CW-1:0]   r_cur_c;
    logic [AW-1:0]   r_clr;

    logic            r_mem_good [MEM_DEPTH];
    logic            r_mem_bad  [MEM_DEPTH];
    logic            r_rd_good;
    logic            r_rd_bad;

    logic [5:0]      r_ant1;
    logic [5:0]      r_ant2;
    logic [4:0]      r_if;
    logic [4:0]      r_ch;

    logic              r_done;
    smfd_pkg::t_result r_out;
    smfd_pkg::t_result n_out;

    logic [6:0]      w_lim;
    logic [5:0]      w_fi;
    logic [5:0]      w_fc;
    logic [5:0]      w_fs;
    logic [12:0]     w_bl_full;
    logic            w_mark_ok;
    logic            w_close;
    logic            w_bank_new;
    logic [LW-1:0]   w_sample_addr;
    logic [LW-1:0]   w_drain_addr;
    logic [AW-1:0]   w_wa;
    logic [AW-1:0]   w_ra;
    logic            w_we_good;
    logic            w_we_bad;
    logic            w_wd;
    logic [NW-1:0]   w_div_num;
    logic [5:0]      w_div_den;
    logic [NW-1:0]   w_quot;
    logic [5:0]      w_rem;
    logic            w_div_done;
    logic [QW-1:0]   w_quot_p1;
    logic [6:0]      w_rem_p1;
    logic [TW-1:0]   w_win_beg;
    logic [TW:0]     w_end_sum;
    logic [TW-1:0]   w_win_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corr_count    <= smfd_pkg::RST_CORR_COUNT;
            r_if_stride     <= smfd_pkg::RST_IF_STRIDE;
            r_chan_stride   <= smfd_pkg::RST_CHAN_STRIDE;
            r_stokes_stride <= smfd_pkg::RST_STOKES_STRIDE;
            r_antenna_limit <= smfd_pkg::RST_ANTENNA_LIMIT;
            r_time_margin   <= smfd_pkg::RST_TIME_MARGIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                smfd_pkg::CFG_CORR_COUNT:    r_corr_count    <= i_cfg_data[4:0];
                smfd_pkg::CFG_IF_STRIDE:     r_if_stride     <= i_cfg_data[4:0];
                smfd_pkg::CFG_CHAN_STRIDE:   r_chan_stride   <= i_cfg_data[4:0];
                smfd_pkg::CFG_STOKES_STRIDE: r_stokes_stride <= i_cfg_data[4:0];
                smfd_pkg::CFG_ANTENNA_LIMIT: r_antenna_limit <= i_cfg_data[5:0];
                smfd_pkg::CFG_TIME_MARGIN:   r_time_margin   <= i_cfg_data[19:0];
                default: begin
                end
            endcase
        end
    end

    assign w_lim = (r_antenna_limit == '0) ? 7'd1 :
                   (7'(r_antenna_limit) > 7'(MAX_ANTENNAS)) ? 7'(MAX_ANTENNAS) :
                   7'(r_antenna_limit);
    assign w_fi  = (r_if_stride == '0)     ? 6'd1 : 6'(r_if_stride);
    assign w_fc  = (r_chan_stride == '0)   ? 6'd1 : 6'(r_chan_stride);
    assign w_fs  = (r_stokes_stride == '0) ? 6'd1 : 6'(r_stokes_stride);

    assign w_bl_full = 13'(r_in.ant_first - 6'd1) * 13'(w_lim)
                     + 13'(r_in.ant_second - 6'd1);

    assign w_mark_ok = (r_in.ant_first != '0) && (7'(r_in.ant_first) <= w_lim)
                    && (r_in.ant_second != '0) && (7'(r_in.ant_second) <= w_lim)
                    && (5'(r_in.corr_index) < r_corr_count)
                    && (7'(r_in.corr_index) < 7'(MAX_CORR));

    assign w_close = r_open && (
        (r_in.action == smfd_pkg::ACT_SAMPLE && r_in.source_id != r_osrc) ||
        (r_in.action == smfd_pkg::ACT_END));
    assign w_bank_new = w_close ? ~r_bank : r_bank;

    assign w_sample_addr = LW'(r_bl) * LW'(MAX_CORR) + LW'(r_in.corr_index);
    assign w_drain_addr  = LW'(r_dbl[BLW-1:0]) * LW'(MAX_CORR) + LW'(r_dc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_item;
        end
        r_bl <= BLW'(w_bl_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank    <= 1'b0;
            r_open    <= 1'b0;
            r_pending <= 1'b0;
            r_ovr     <= 1'b0;
            r_osrc    <= '0;
            r_osub    <= '0;
            r_obeg    <= '0;
            r_oend    <= '0;
            r_csrc    <= '0;
            r_csub    <= '0;
            r_cbeg    <= '0;
            r_cend    <= '0;
            r_dbl     <= '0;
            r_dc      <= '0;
            r_clr     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_ovr <= 1'b0;
            end
            if (i_cmd.set_ovr) begin
                r_ovr <= 1'b1;
                r_clr <= '0;
            end
            if (i_cmd.clr_en) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.commit) begin
                if (w_close) begin
                    r_csrc    <= r_osrc;
                    r_csub    <= r_osub;
                    r_cbeg    <= r_obeg;
                    r_cend    <= r_oend;
                    r_bank    <= ~r_bank;
                    r_pending <= 1'b1;
                    r_dbl     <= '0;
                    r_dc      <= '0;
                end
                if (r_in.action == smfd_pkg::ACT_SAMPLE) begin
                    if (!r_open) begin
                        r_open <= 1'b1;
                        r_osrc <= r_in.source_id;
                        r_osub <= r_in.subarray;
                        r_obeg <= r_in.sample_time;
                        r_oend <= r_in.sample_time;
                    end else if (w_close) begin
                        r_osrc <= r_in.source_id;
                        r_osub <= r_in.subarray;
                        if (r_in.sample_time > r_obeg) begin
                            r_obeg <= r_in.sample_time;
                        end
                        if (r_in.sample_time > r_oend) begin
                            r_oend <= r_in.sample_time;
                        end
                    end else if (r_in.sample_time > r_oend) begin
                        r_oend <= r_in.sample_time;
                    end
                end else begin
                    r_open <= 1'b0;
                end
            end
            if (i_cmd.rd_clear) begin
                if (r_dc == CW'(MAX_CORR - 1)) begin
                    r_dc  <= '0;
                    r_dbl <= r_dbl + PW'(1);
                end else begin
                    r_dc <= r_dc + CW'(1);
                end
            end
            if (i_cmd.drain_end) begin
                r_pending <= 1'b0;
                r_dbl     <= '0;
                r_dc      <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_clear) begin
            r_cur_bl <= r_dbl[BLW-1:0];
            r_cur_c  <= r_dc;
        end
    end

    always_comb begin
        w_wa      = {~r_bank, w_drain_addr};
        w_we_good = 1'b0;
        w_we_bad  = 1'b0;
        w_wd      = 1'b0;
        if (i_cmd.clr_en) begin
            w_wa      = i_cmd.clr_all ? r_clr : {~r_bank, r_clr[LW-1:0]};
            w_we_good = 1'b1;
            w_we_bad  = 1'b1;
        end else if (i_cmd.commit) begin
            w_wa      = {w_bank_new, w_sample_addr};
            w_wd      = 1'b1;
            w_we_good = (r_in.action == smfd_pkg::ACT_SAMPLE) && w_mark_ok
                        && r_in.weight_positive;
            w_we_bad  = (r_in.action == smfd_pkg::ACT_SAMPLE) && w_mark_ok
                        && !r_in.weight_positive;
        end else if (i_cmd.rd_clear) begin
            w_we_good = 1'b1;
            w_we_bad  = 1'b1;
        end
    end

    assign w_ra = {~r_bank, w_drain_addr};

    always_ff @(posedge i_clk) begin
        if (w_we_good) begin
            r_mem_good[w_wa] <= w_wd;
        end
        if (w_we_bad) begin
            r_mem_bad[w_wa] <= w_wd;
        end
        r_rd_good <= r_mem_good[w_ra];
        r_rd_bad  <= r_mem_bad[w_ra];
    end

    always_comb begin
        case (i_cmd.load_sel)
            smfd_pkg::DIV_BL: begin
                w_div_num = NW'(r_cur_bl);
                w_div_den = 6'(w_lim);
            end
            smfd_pkg::DIV_IF: begin
                w_div_num = NW'(r_cur_c);
                w_div_den = w_fi;
            end
            smfd_pkg::DIV_CH: begin
                w_div_num = NW'(w_rem);
                w_div_den = w_fc;
            end
            default: begin
                w_div_num = NW'(w_rem);
                w_div_den = w_fs;
            end
        endcase
    end

    smfd_div #(
        .NUM_W (NW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_cmd.div_load),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_quot  (w_quot),
        .o_rem   (w_rem),
        .o_done  (w_div_done)
    );

    assign w_quot_p1 = {1'b0, w_quot} + QW'(1);
    assign w_rem_p1  = {1'b0, w_rem} + 7'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            case (i_cmd.cap_sel)
                smfd_pkg::DIV_BL: begin
                    r_ant1 <= 6'(w_quot_p1);
                    r_ant2 <= w_rem_p1[5:0];
                end
                smfd_pkg::DIV_IF: r_if <= 5'(w_quot_p1);
                smfd_pkg::DIV_CH: r_ch <= 5'(w_quot_p1);
                default: begin
                end
            endcase
        end
    end

    assign w_win_beg = (r_cbeg > TW'(r_time_margin)) ? r_cbeg - TW'(r_time_margin) : '0;
    assign w_end_sum = {1'b0, r_cend} + (TW + 1)'(r_time_margin);
    assign w_win_end = (w_end_sum > {1'b0, smfd_pkg::TIME_MAX}) ? smfd_pkg::TIME_MAX
                                                               : w_end_sum[TW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
    end

    always_comb begin
        n_out        = '0;
        n_out.status = i_cmd.emit_status;
        if (i_cmd.emit_status == smfd_pkg::STS_FLAG) begin
            n_out.flag_source     = r_csrc;
            n_out.flag_subarray   = r_csub;
            n_out.window_begin    = w_win_beg;
            n_out.window_end      = w_win_end;
            n_out.flag_ant_first  = r_ant1;
            n_out.flag_ant_second = r_ant2;
            n_out.flag_if         = r_if;
            n_out.flag_channel    = r_ch;
            n_out.flag_stokes     = 4'(w_quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

    always_comb begin
        o_stat               = '0;
        o_stat.action        = r_in.action;
        o_stat.close_req     = w_close;
        o_stat.scan_open     = r_open;
        o_stat.pending       = r_pending;
        o_stat.overrun       = r_ovr;
        o_stat.ptr_end       = (r_dbl == PW'(MAX_ANTENNAS * MAX_ANTENNAS));
        o_stat.hit           = r_rd_good && r_rd_bad;
        o_stat.div_done      = w_div_done;
        o_stat.clr_last_all  = (r_clr == '1);
        o_stat.clr_last_bank = (r_clr[LW-1:0] == '1);
    end

endmodule

// ===== rtl/smfd_checker.sv =====
// ----------------------------------------------------------------------------
// smfd_checker
// Port-level checks of the scan mixed-flag detector, bound to the top level.
// ----------------------------------------------------------------------------
module smfd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input smfd_pkg::t_result o_result
);

    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while the block is busy");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an item transfer");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results in consecutive cycles");

    a_plain_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != smfd_pkg::STS_FLAG) |->
            (o_result.flag_source == '0 && o_result.window_end == '0
             && o_result.flag_if == '0))
        else $error("non-flag result carries field data");

    a_flag_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == smfd_pkg::STS_FLAG) |->
            (o_result.flag_if != '0 && o_result.flag_channel != '0
             && o_result.window_begin <= o_result.window_end))
        else $error("flag record with bad IF, channel or window");

endmodule

bind scan_mixed_flag_detector smfd_checker u_smfd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
